### src/slip_deframer_crc_check_assert.svh
// Assertion macros shared by the SLIP deframer modules.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef SLIP_DEFRAMER_CRC_CHECK_ASSERT_SVH
`define SLIP_DEFRAMER_CRC_CHECK_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define SDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define SDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### src/sdc_pkg.sv
// Types, constants and helper functions for the SLIP deframer with CRC check.
// Used by every module of the block; no dependencies.
package sdc_pkg;

  localparam int unsigned MAX_FRAME = 1024;
  localparam int unsigned FC_W      = $clog2(MAX_FRAME + 1);

  localparam logic [7:0] BYTE_END     = 8'hC0;
  localparam logic [7:0] BYTE_ESC     = 8'hDB;
  localparam logic [7:0] BYTE_ESC_END = 8'hDC;
  localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_CONSOLE = 3'd1;
  localparam logic [2:0] KIND_GOOD    = 3'd2;
  localparam logic [2:0] KIND_BAD     = 3'd3;
  localparam logic [2:0] KIND_CEND    = 3'd4;

  localparam logic [15:0] CRC_POLY = 16'h8408;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } res_t;

  // Results caused by one item, first result in ent[0].
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     ent;
  } res_list_t;

  function automatic logic is_text(input logic [7:0] b);
    is_text = (b >= 8'h20 && b <= 8'h7E) || b == 8'h0A || b == 8'h0D;
  endfunction

  // Reflected CCITT update, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_byte = c;
  endfunction

endpackage

### src/sdc_core.sv
// Frame state and per-item decode: escape handling, console detection,
// two-byte hold-back and CRC accumulation. Depends on sdc_pkg.
`include "slip_deframer_crc_check_assert.svh"

module sdc_core
  import sdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] rx_byte_i,
  output res_list_t  list_o
);

  logic            esc_q, esc_d;
  logic            pkt_q, pkt_d;
  logic [FC_W-1:0] fc_q, fc_d;
  logic [7:0]      h0_q, h0_d;
  logic [7:0]      h1_q, h1_d;
  logic [15:0]     crc_q, crc_d;

  logic            keep_en;
  logic [7:0]      keep_b;
  res_list_t       lst;

  always_comb begin
    esc_d   = esc_q;
    pkt_d   = pkt_q;
    fc_d    = fc_q;
    h0_d    = h0_q;
    h1_d    = h1_q;
    crc_d   = crc_q;
    lst     = '0;
    keep_en = 1'b0;
    keep_b  = rx_byte_i;

    if (rx_byte_i == BYTE_END) begin
      if (fc_q != '0) begin
        if (!pkt_q) begin
          lst.ent[0] = '{kind: KIND_CEND, data: 8'h00};
          lst.cnt    = 2'd1;
        end else if (fc_q <= FC_W'(2)) begin
          // short frame: flush the held bytes as console text
          lst.ent[0] = '{kind: KIND_CONSOLE, data: h0_q};
          if (fc_q == FC_W'(2)) begin
            lst.ent[1] = '{kind: KIND_CONSOLE, data: h1_q};
            lst.ent[2] = '{kind: KIND_CEND, data: 8'h00};
            lst.cnt    = 2'd3;
          end else begin
            lst.ent[1] = '{kind: KIND_CEND, data: 8'h00};
            lst.cnt    = 2'd2;
          end
        end else begin
          lst.ent[0].kind = ({h1_q, h0_q} == crc_q) ? KIND_GOOD : KIND_BAD;
          lst.ent[0].data = 8'h00;
          lst.cnt         = 2'd1;
        end
      end
      pkt_d = 1'b1;
      esc_d = 1'b0;
      fc_d  = '0;
      h0_d  = 8'h00;
      h1_d  = 8'h00;
      crc_d = 16'h0000;
    end else if (esc_q) begin
      esc_d   = 1'b0;
      keep_en = 1'b1;
      if (rx_byte_i == BYTE_ESC_END) begin
        keep_b = BYTE_END;
      end else if (rx_byte_i == BYTE_ESC_ESC) begin
        keep_b = BYTE_ESC;
      end
    end else if (pkt_q && rx_byte_i == BYTE_ESC) begin
      esc_d = 1'b1;
    end else if (!pkt_q) begin
      lst.ent[0] = '{kind: KIND_CONSOLE, data: rx_byte_i};
      lst.cnt    = 2'd1;
      if (fc_q < FC_W'(MAX_FRAME)) fc_d = fc_q + FC_W'(1);
    end else if (fc_q == FC_W'(1) && is_text(h0_q) && is_text(rx_byte_i)) begin
      // two text bytes open the frame: switch to console
      pkt_d      = 1'b0;
      lst.ent[0] = '{kind: KIND_CONSOLE, data: h0_q};
      lst.ent[1] = '{kind: KIND_CONSOLE, data: rx_byte_i};
      lst.cnt    = 2'd2;
      if (fc_q < FC_W'(MAX_FRAME)) fc_d = fc_q + FC_W'(1);
    end else begin
      keep_en = 1'b1;
    end

    // keep a packet byte; release the oldest held byte as payload
    if (keep_en && fc_q < FC_W'(MAX_FRAME)) begin
      fc_d = fc_q + FC_W'(1);
      if (fc_q >= FC_W'(2)) begin
        lst.ent[0] = '{kind: KIND_PAYLOAD, data: h0_q};
        lst.cnt    = 2'd1;
        crc_d      = crc_byte(crc_q, h0_q);
        h0_d       = h1_q;
        h1_d       = keep_b;
      end else if (!fc_q[0]) begin
        h0_d = keep_b;
      end else begin
        h1_d = keep_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      pkt_q <= 1'b0;
      fc_q  <= '0;
      h0_q  <= 8'h00;
      h1_q  <= 8'h00;
      crc_q <= 16'h0000;
    end else if (acc_i) begin
      esc_q <= esc_d;
      pkt_q <= pkt_d;
      fc_q  <= fc_d;
      h0_q  <= h0_d;
      h1_q  <= h1_d;
      crc_q <= crc_d;
    end
  end

  assign list_o = lst;

  `SDC_ASSERT(a_esc_in_pkt, clk_i, rst_ni, esc_q |-> pkt_q, "escape pending outside a packet")
  `SDC_ASSERT(a_fc_max, clk_i, rst_ni, fc_q <= FC_W'(MAX_FRAME), "frame count above maximum")
  `SDC_ASSERT(a_crc_early, clk_i, rst_ni, (fc_q < FC_W'(3)) |-> (crc_q == 16'h0000), "CRC moved before third byte")

endmodule

### src/sdc_outbuf.sv
// Result register: holds the up to three results of one item and hands
// them out one per cycle unless stalled, marking the final one. Depends on sdc_pkg.
`include "slip_deframer_crc_check_assert.svh"

module sdc_outbuf
  import sdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       acc_o,
  input  res_list_t  list_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] data_o,
  output logic       last_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t [2:0] ent_q, ent_d;
  logic       pop;
  logic       can_load;

  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && !out_stall_i;
  // take the next item once the last waiting result leaves
  assign can_load    = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
  assign in_stall_o  = !can_load;
  assign acc_o       = in_valid_i && can_load;

  always_comb begin
    cnt_d = cnt_q;
    ent_d = ent_q;
    if (acc_o) begin
      cnt_d = list_i.cnt;
      ent_d = list_i.ent;
    end else if (pop) begin
      cnt_d    = cnt_q - 2'd1;
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign kind_o = ent_q[0].kind;
  assign data_o = ent_q[0].data;
  assign last_o = cnt_q == 2'd1;

  `SDC_ASSERT(a_payload_last, clk_i, rst_ni, (out_valid_o && kind_o == KIND_PAYLOAD) |-> last_o, "payload not alone")
  `SDC_ASSERT(a_end_last, clk_i, rst_ni, (out_valid_o && (kind_o == KIND_GOOD || kind_o == KIND_BAD || kind_o == KIND_CEND)) |-> (last_o && data_o == 8'h00), "end marker not final or data set")
  `SDC_ASSERT(a_drain, clk_i, rst_ni, (pop && cnt_q > 2'd1) |=> out_valid_o, "results lost while draining")

endmodule

### src/slip_deframer_crc_check.sv
// SLIP deframer with CRC-16 check. One received byte is taken per item and
// turned into zero to three results (payload byte, console byte, CRC good or
// bad marker, console end), the final one flagged by last_o. Results appear
// in the cycle after their item is accepted and leave one per cycle, while
// out_stall_i is low, from a three-entry result register; an item holds that
// register until its final result is delivered, and the next item is taken in
// that cycle, so items with one or no result run at one per cycle while the
// output does not stall. Packet bytes come out two bytes late, as the last
// two bytes of a packet carry the little-endian CRC. Depends on sdc_pkg,
// sdc_core and sdc_outbuf.
module slip_deframer_crc_check
  import sdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] data_o,
  output logic       last_o
);

  logic      acc;
  res_list_t list;

  sdc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .rx_byte_i (rx_byte_i),
    .list_o    (list)
  );

  sdc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .acc_o       (acc),
    .list_i      (list),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

endmodule

### tb/sv/slip_deframer_crc_check_chk.sv
// Result checker for the SLIP deframer: predicts the results of every accepted
// item and compares them in order with the block's output. Uses sdc_pkg.
`timescale 1ns / 1ps

package slip_tb_pkg;

  // Bit-serial reflected CCITT update, one byte, LSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) begin
        r = (r >> 1) ^ sdc_pkg::CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

module slip_deframer_crc_check_chk
  import sdc_pkg::*;
  import slip_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  data_i,
  input  logic        last_i,
  output int unsigned due_cnt_o,
  output int unsigned fail_cnt_o
);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } slip_res_t;

  logic            esc_q;
  logic            pkt_q;
  logic [FC_W-1:0] fc_q;
  logic [7:0]      held_q [2];
  logic [15:0]     crc_q;

  slip_res_t due_results [$];
  slip_res_t step_r [3];
  int        step_n;

  function automatic logic printable(input logic [7:0] b);
    return (b inside {[8'h20:8'h7E]}) || b == 8'h0A || b == 8'h0D;
  endfunction

  task automatic open_frame();
    pkt_q     = 1'b1;
    esc_q     = 1'b0;
    fc_q      = '0;
    held_q[0] = 8'h00;
    held_q[1] = 8'h00;
    crc_q     = 16'h0000;
  endtask

  task automatic add_result(input logic [2:0] k_in, input logic [7:0] d_in);
    step_r[step_n] = '{kind: k_in, data: d_in, last: 1'b0};
    step_n++;
  endtask

  // Keep one decoded packet byte; the oldest held byte leaves as payload.
  task automatic keep_byte(input logic [7:0] b);
    if (fc_q >= MAX_FRAME) begin
      return;
    end
    if (fc_q >= 2) begin
      add_result(KIND_PAYLOAD, held_q[0]);
      crc_q     = crc16_step(crc_q, held_q[0]);
      held_q[0] = held_q[1];
      held_q[1] = b;
    end else begin
      held_q[fc_q[0]] = b;
    end
    fc_q = fc_q + 1'b1;
  endtask

  task automatic deframe_byte(input logic [7:0] rx);
    logic [7:0] c;
    c      = rx;
    step_n = 0;
    if (c == BYTE_END) begin
      if (fc_q != 0) begin
        if (!pkt_q) begin
          add_result(KIND_CEND, 8'h00);
        end else if (fc_q <= 2) begin
          // too short for a CRC: hand it out as console text
          add_result(KIND_CONSOLE, held_q[0]);
          if (fc_q == 2) begin
            add_result(KIND_CONSOLE, held_q[1]);
          end
          add_result(KIND_CEND, 8'h00);
        end else begin
          add_result(({held_q[1], held_q[0]} == crc_q) ? KIND_GOOD : KIND_BAD, 8'h00);
        end
      end
      open_frame();
    end else if (esc_q) begin
      if (c == BYTE_ESC_END) begin
        c = BYTE_END;
      end else if (c == BYTE_ESC_ESC) begin
        c = BYTE_ESC;
      end
      esc_q = 1'b0;
      keep_byte(c);
    end else if (pkt_q && c == BYTE_ESC) begin
      esc_q = 1'b1;
    end else if (!pkt_q) begin
      add_result(KIND_CONSOLE, c);
      if (fc_q < MAX_FRAME) begin
        fc_q = fc_q + 1'b1;
      end
    end else if (fc_q == 1 && printable(held_q[0]) && printable(c)) begin
      // two leading text bytes turn the frame into console text
      pkt_q = 1'b0;
      add_result(KIND_CONSOLE, held_q[0]);
      add_result(KIND_CONSOLE, c);
      fc_q = fc_q + 1'b1;
    end else begin
      keep_byte(c);
    end
    if (step_n > 0) begin
      step_r[step_n-1].last = 1'b1;
    end
    for (int k = 0; k < step_n; k++) begin
      due_results.push_back(step_r[k]);
    end
  endtask

  task automatic check_result();
    slip_res_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result kind=%0d data=%02h last=%0b",
               $time, kind_i, data_i, last_i);
      fail_cnt_o++;
    end else begin
      want = due_results.pop_front();
      if (want.kind !== kind_i || want.data !== data_i || want.last !== last_i) begin
        $display("%0t: result mismatch: expected kind=%0d data=%02h last=%0b, got kind=%0d data=%02h last=%0b",
                 $time, want.kind, want.data, want.last, kind_i, data_i, last_i);
        fail_cnt_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_frame();
      pkt_q = 1'b0;
      due_results.delete();
      due_cnt_o  = 0;
      fail_cnt_o = 0;
    end else begin
      // results leave only after their item is registered, so compare before predicting
      if (out_valid_i && !out_stall_i) begin
        check_result();
      end
      if (in_valid_i && !in_stall_i) begin
        deframe_byte(rx_byte_i);
      end
      due_cnt_o = due_results.size();
    end
  end

endmodule

### tb/sv/slip_deframer_crc_check_test.sv
// Testbench top for the SLIP deframer: drives framed byte streams with random
// idling and gives the verdict. Depends on sdc_pkg and slip_deframer_crc_check_chk.
`timescale 1ns / 1ps

module slip_deframer_crc_check_test;
  import sdc_pkg::*;
  import slip_tb_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 10;

  localparam logic [7:0] OPENING [28] = '{
    8'h00, 8'hFF, BYTE_ESC, 8'h41, BYTE_END,       // ahead of the first END
    BYTE_END,                                      // empty frame
    8'h0A, 8'h0D, 8'h20, 8'h7E, BYTE_END,          // console frame
    8'h1F, 8'h7F, BYTE_END,                        // two-byte packet
    BYTE_ESC, 8'h41, 8'h42, BYTE_END,              // escaped first, plain second
    8'h41, BYTE_ESC, 8'h42, 8'h43, BYTE_END,       // escaped second stays a packet
    BYTE_ESC, BYTE_END,                            // escape cut off by END
    8'h01, BYTE_ESC, BYTE_END                      // one-byte packet, dangling escape
  };
  localparam logic [7:0] CODE_BYTES [4] = '{BYTE_END, BYTE_ESC, BYTE_ESC_END, BYTE_ESC_ESC};

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] kind;
  logic [7:0] data;
  logic       last;

  int unsigned due_cnt;
  int unsigned fail_cnt;
  int unsigned send_idle = 18;
  int unsigned recv_idle = 84;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  bit          hold_req = 1'b0;

  slip_deframer_crc_check i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .data_o      (data),
    .last_o      (last)
  );

  slip_deframer_crc_check_chk i_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .rx_byte_i   (rx_byte),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .kind_i      (kind),
    .data_i      (data),
    .last_i      (last),
    .due_cnt_o   (due_cnt),
    .fail_cnt_o  (fail_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("slip_deframer_crc_check_test failed");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_coded(input logic [7:0] b, input bit esc_other);
    if (b == BYTE_END) begin
      put_byte(BYTE_ESC);
      put_byte(BYTE_ESC_END);
    end else if (b == BYTE_ESC) begin
      put_byte(BYTE_ESC);
      put_byte(BYTE_ESC_ESC);
    end else begin
      if (esc_other && b != BYTE_ESC_END && b != BYTE_ESC_ESC) begin
        put_byte(BYTE_ESC);
      end
      put_byte(b);
    end
  endtask

  task automatic put_frame(input logic [7:0] body [$], input bit esc_all);
    put_byte(BYTE_END);
    foreach (body[i]) begin
      put_coded(body[i], esc_all || (i == 1 && $urandom_range(1) == 1) ||
                         $urandom_range(19) == 0);
    end
    put_byte(BYTE_END);
  endtask

  // Packet with trailing little-endian CRC, good or corrupted.
  task automatic put_packet(input int unsigned len, input bit good, input bit esc_all);
    logic [7:0]  body [$];
    logic [7:0]  b;
    logic [15:0] crc;
    crc = 16'h0000;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0) begin
        b = CODE_BYTES[$urandom_range(3)];
      end else begin
        b = 8'($urandom_range(255));
      end
      // mostly keep the lead byte non-text so the frame stays a packet
      if (i == 0 && $urandom_range(4) != 0) begin
        b[7] = 1'b1;
      end
      body.push_back(b);
      crc = crc16_step(crc, b);
    end
    if (!good) begin
      crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    end
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    put_frame(body, esc_all);
  endtask

  task automatic put_random(input int unsigned n);
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  b;
    goal = items_sent + n;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        put_packet($urandom_range(0, 10), $urandom_range(99) < 80, 1'b0);
      end else if (pick < 82) begin
        put_byte(BYTE_END);
        len = $urandom_range(1, 10);
        repeat (len) begin
          if ($urandom_range(9) == 0) begin
            b = $urandom_range(1) ? 8'h0A : 8'h0D;
          end else begin
            b = 8'($urandom_range(8'h20, 8'h7E));
          end
          put_byte(b);
        end
        put_byte(BYTE_END);
      end else begin
        // noise: loose ENDs and escapes among random bytes
        len = $urandom_range(1, 8);
        repeat (len) begin
          pick = $urandom_range(99);
          if (pick < 15) begin
            b = BYTE_END;
          end else if (pick < 30) begin
            b = BYTE_ESC;
          end else begin
            b = 8'($urandom_range(255));
          end
          put_byte(b);
        end
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_cnt != 0) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (OPENING[i]) begin
      put_byte(OPENING[i]);
    end
    put_packet(3, 1'b1, 1'b1);
    put_packet(3, 1'b0, 1'b0);
    put_random(115);
    wait_drained();

    send_idle = 84;
    recv_idle = 18;
    put_random(115);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    // receiver holds off while items keep coming
    hold_req = 1'b1;
    put_packet(12, 1'b1, 1'b0);
    wait_drained();
    put_random(115);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("slip_deframer_crc_check_test passed");
    end else begin
      $display("slip_deframer_crc_check_test failed");
    end
    $finish;
  end

endmodule

### slip_deframer_crc_check.f
+incdir+src
src/sdc_pkg.sv
src/sdc_core.sv
src/sdc_outbuf.sv
src/slip_deframer_crc_check.sv
tb/sv/slip_deframer_crc_check_chk.sv
tb/sv/slip_deframer_crc_check_test.sv
